// File: src/lswc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line segment window clipper package
// Shared constants and types for the clipper, its interfaces and its stages.
// ----------------------------------------------------------------------------
package lswc_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 2;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_X_MIN = 2'd0,
    REG_Y_MIN = 2'd1,
    REG_X_MAX = 2'd2,
    REG_Y_MAX = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    EDGE_TOP    = 2'd0,
    EDGE_BOTTOM = 2'd1,
    EDGE_RIGHT  = 2'd2,
    EDGE_LEFT   = 2'd3
  } edge_sel_t;

endpackage
`default_nettype wire

// File: src/lswc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clipper channel interfaces
// Segment request channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface lswc_seg_if #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lswc_res_if #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] clipped_start_x;
  logic signed [COORD_WIDTH-1:0] clipped_start_y;
  logic signed [COORD_WIDTH-1:0] clipped_end_x;
  logic signed [COORD_WIDTH-1:0] clipped_end_y;
  logic                          visible;
  modport source (output valid, clipped_start_x, clipped_start_y, clipped_end_x,
                  clipped_end_y, visible, input ready);
  modport sink (input valid, clipped_start_x, clipped_start_y, clipped_end_x,
                clipped_end_y, visible, output ready);
endinterface

interface lswc_cfg_if #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH
);
  logic                                  valid;
  logic                                  ready;
  logic [lswc_pkg::CFG_IDX_WIDTH-1:0]    index;
  logic [COORD_WIDTH-1:0]                data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: src/lswc_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clipper boundary stage
// Clips both endpoints against one boundary. A pipelined restoring divider
// forms the intersection, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module lswc_stage #(
  parameter int                 COORD_WIDTH = lswc_pkg::COORD_WIDTH,
  parameter lswc_pkg::edge_sel_t EDGE = lswc_pkg::EDGE_TOP
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           en,
  input  wire                           in_valid,
  input  wire                           in_vis,
  input  wire signed [COORD_WIDTH-1:0]  in_x1,
  input  wire signed [COORD_WIDTH-1:0]  in_y1,
  input  wire signed [COORD_WIDTH-1:0]  in_x2,
  input  wire signed [COORD_WIDTH-1:0]  in_y2,
  input  wire signed [COORD_WIDTH-1:0]  edge_val,
  output logic                          out_valid,
  output logic                          out_vis,
  output logic signed [COORD_WIDTH-1:0] out_x1,
  output logic signed [COORD_WIDTH-1:0] out_y1,
  output logic signed [COORD_WIDTH-1:0] out_x2,
  output logic signed [COORD_WIDTH-1:0] out_y2
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int QW = DW;
  localparam int NS = QW + 2;
  localparam bit IS_Y = (EDGE == lswc_pkg::EDGE_TOP) || (EDGE == lswc_pkg::EDGE_BOTTOM);
  localparam bit IS_MAX = (EDGE == lswc_pkg::EDGE_TOP) || (EDGE == lswc_pkg::EDGE_RIGHT);

  typedef struct packed {
    logic                   valid;
    logic                   vis;
    logic                   o1;
    logic                   o2;
    logic [COORD_WIDTH-1:0] x1;
    logic [COORD_WIDTH-1:0] y1;
    logic [COORD_WIDTH-1:0] x2;
    logic [COORD_WIDTH-1:0] y2;
    logic [COORD_WIDTH-1:0] e;
    logic                   neg1;
    logic                   neg2;
    logic [PW-1:0]          n1;
    logic [PW-1:0]          n2;
    logic [DW-1:0]          d;
    logic [PW-1:0]          r1;
    logic [PW-1:0]          r2;
    logic [QW-1:0]          q1;
    logic [QW-1:0]          q2;
  } pipe_t;

  pipe_t pipe_r [NS];
  pipe_t pipe_nxt [NS];

  // Stage 0: outside tests and the differences.
  logic signed [COORD_WIDTH-1:0] a1, b1, a2, b2;
  logic o1, o2;
  logic signed [DW-1:0] db, ta1, ta2, dd;
  logic [DW-1:0] mdb, mt1, mt2, mdd;

  always_comb begin
    a1 = IS_Y ? in_y1 : in_x1;
    b1 = IS_Y ? in_x1 : in_y1;
    a2 = IS_Y ? in_y2 : in_x2;
    b2 = IS_Y ? in_x2 : in_y2;
    o1 = IS_MAX ? (a1 > edge_val) : (a1 < edge_val);
    o2 = IS_MAX ? (a2 > edge_val) : (a2 < edge_val);
    db = DW'(b2) - DW'(b1);
    dd = DW'(a2) - DW'(a1);
    ta1 = DW'(edge_val) - DW'(a1);
    ta2 = DW'(edge_val) - DW'(a2);
    mdb = db[DW-1] ? DW'(-db) : DW'(db);
    mdd = dd[DW-1] ? DW'(-dd) : DW'(dd);
    mt1 = ta1[DW-1] ? DW'(-ta1) : DW'(ta1);
    mt2 = ta2[DW-1] ? DW'(-ta2) : DW'(ta2);
    pipe_nxt[0] = '0;
    pipe_nxt[0].valid = in_valid;
    pipe_nxt[0].vis = in_vis && !(o1 && o2);
    pipe_nxt[0].o1 = o1;
    pipe_nxt[0].o2 = o2;
    pipe_nxt[0].x1 = in_x1;
    pipe_nxt[0].y1 = in_y1;
    pipe_nxt[0].x2 = in_x2;
    pipe_nxt[0].y2 = in_y2;
    pipe_nxt[0].e = edge_val;
    // Signs: n1 = db*ta1/(dd); n2 = (-db)*ta2/(-dd), same sign rule.
    pipe_nxt[0].neg1 = db[DW-1] ^ ta1[DW-1] ^ dd[DW-1];
    pipe_nxt[0].neg2 = db[DW-1] ^ ta2[DW-1] ^ dd[DW-1];
    pipe_nxt[0].n1 = PW'(mdb);
    pipe_nxt[0].n2 = PW'(mt1);
    pipe_nxt[0].r1 = PW'(mt2);
    pipe_nxt[0].d = mdd;
  end

  // Stage 1: the two products.
  always_comb begin
    pipe_nxt[1] = pipe_r[0];
    pipe_nxt[1].n1 = PW'(pipe_r[0].n1[DW-1:0] * pipe_r[0].n2[DW-1:0]);
    pipe_nxt[1].n2 = PW'(pipe_r[0].n1[DW-1:0] * pipe_r[0].r1[DW-1:0]);
    pipe_nxt[1].r1 = '0;
    pipe_nxt[1].r2 = '0;
    pipe_nxt[1].q1 = '0;
    pipe_nxt[1].q2 = '0;
  end

  // Division stages, one quotient bit each, most significant first.
  // When only one endpoint lies outside, its quotient magnitude never exceeds the numerator side difference.
  for (genvar s = 2; s < NS; s++) begin : g_div
    localparam int BIT = NS - 1 - s;
    logic [PW-1:0] t1, t2, sh;
    always_comb begin
      pipe_nxt[s] = pipe_r[s-1];
      sh = PW'(pipe_r[s-1].d) << BIT;
      t1 = pipe_r[s-1].n1;
      t2 = pipe_r[s-1].n2;
      if ((pipe_r[s-1].d != '0) && (t1 >= sh) && ((sh >> BIT) == PW'(pipe_r[s-1].d))) begin
        pipe_nxt[s].n1 = t1 - sh;
        pipe_nxt[s].q1[BIT] = 1'b1;
      end
      if ((pipe_r[s-1].d != '0) && (t2 >= sh) && ((sh >> BIT) == PW'(pipe_r[s-1].d))) begin
        pipe_nxt[s].n2 = t2 - sh;
        pipe_nxt[s].q2[BIT] = 1'b1;
      end
    end
  end

  for (genvar s = 0; s < NS; s++) begin : g_regs
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[s].valid <= 1'b0;
      end else if (en) begin
        pipe_r[s].valid <= pipe_nxt[s].valid;
      end
      if (en) begin
        pipe_r[s].vis <= pipe_nxt[s].vis;
        pipe_r[s].o1 <= pipe_nxt[s].o1;
        pipe_r[s].o2 <= pipe_nxt[s].o2;
        pipe_r[s].x1 <= pipe_nxt[s].x1;
        pipe_r[s].y1 <= pipe_nxt[s].y1;
        pipe_r[s].x2 <= pipe_nxt[s].x2;
        pipe_r[s].y2 <= pipe_nxt[s].y2;
        pipe_r[s].e <= pipe_nxt[s].e;
        pipe_r[s].neg1 <= pipe_nxt[s].neg1;
        pipe_r[s].neg2 <= pipe_nxt[s].neg2;
        pipe_r[s].n1 <= pipe_nxt[s].n1;
        pipe_r[s].n2 <= pipe_nxt[s].n2;
        pipe_r[s].d <= pipe_nxt[s].d;
        pipe_r[s].r1 <= pipe_nxt[s].r1;
        pipe_r[s].r2 <= pipe_nxt[s].r2;
        pipe_r[s].q1 <= pipe_nxt[s].q1;
        pipe_r[s].q2 <= pipe_nxt[s].q2;
      end
    end
  end

  // Final combine: apply sign, add to the other coordinate, move onto edge.
  pipe_t l;
  logic signed [DW-1:0] sq1, sq2, nb1, nb2;
  logic [COORD_WIDTH-1:0] fb1, fb2;

  always_comb begin
    l = pipe_r[NS-1];
    sq1 = l.neg1 ? DW'(-$signed(l.q1)) : $signed(l.q1);
    sq2 = l.neg2 ? DW'(-$signed(l.q2)) : $signed(l.q2);
    nb1 = DW'($signed(IS_Y ? l.x1 : l.y1)) + sq1;
    nb2 = DW'($signed(IS_Y ? l.x2 : l.y2)) + sq2;
    fb1 = l.o1 ? nb1[COORD_WIDTH-1:0] : (IS_Y ? l.x1 : l.y1);
    fb2 = l.o2 ? nb2[COORD_WIDTH-1:0] : (IS_Y ? l.x2 : l.y2);
    out_valid = l.valid;
    out_vis = l.vis;
    if (IS_Y) begin
      out_x1 = fb1;
      out_x2 = fb2;
      out_y1 = l.o1 ? l.e : l.y1;
      out_y2 = l.o2 ? l.e : l.y2;
    end else begin
      out_y1 = fb1;
      out_y2 = fb2;
      out_x1 = l.o1 ? l.e : l.x1;
      out_x2 = l.o2 ? l.e : l.x2;
    end
  end

endmodule
`default_nettype wire

// File: src/line_segment_window_clipper.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Line segment window clipper
// Cohen-Sutherland clipping of one segment per request against a window.
// ----------------------------------------------------------------------------
// The block accepts one segment request per clock while the result channel is
// not stalled, and returns one result per request in order. Each request passes
// four boundary stages (top, bottom, right, left), each a chain of registers
// because the intersection divider resolves one quotient bit per register,
// then a final inside check and an output register. The window registers are
// read at each stage, so write them only while no request is in flight. A
// rejected segment returns zero coordinates.
module line_segment_window_clipper #(
  parameter int COORD_WIDTH = lswc_pkg::COORD_WIDTH
) (
  input wire clk,
  input wire rst_n,
  lswc_seg_if.sink   in_ch,
  lswc_res_if.source out_ch,
  lswc_cfg_if.sink   cfg_ch
);

  logic signed [COORD_WIDTH-1:0] x_min_r, y_min_r, x_max_r, y_max_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r <= '0;
      y_min_r <= '0;
      x_max_r <= COORD_WIDTH'(32767);
      y_max_r <= COORD_WIDTH'(32767);
    end else if (cfg_ch.valid) begin
      unique case (lswc_pkg::cfg_reg_t'(cfg_ch.index))
        lswc_pkg::REG_X_MIN: x_min_r <= cfg_ch.data;
        lswc_pkg::REG_Y_MIN: y_min_r <= cfg_ch.data;
        lswc_pkg::REG_X_MAX: x_max_r <= cfg_ch.data;
        lswc_pkg::REG_Y_MAX: y_max_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  logic en;
  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  logic                          v [5];
  logic                          vis [5];
  logic signed [COORD_WIDTH-1:0] x1 [5], y1 [5], x2 [5], y2 [5];
  logic signed [COORD_WIDTH-1:0] edges [4];

  assign v[0] = in_ch.valid && en;
  assign vis[0] = 1'b1;
  assign x1[0] = in_ch.start_x;
  assign y1[0] = in_ch.start_y;
  assign x2[0] = in_ch.end_x;
  assign y2[0] = in_ch.end_y;
  assign edges[0] = y_max_r;
  assign edges[1] = y_min_r;
  assign edges[2] = x_max_r;
  assign edges[3] = x_min_r;

  for (genvar k = 0; k < 4; k++) begin : g_stage
    lswc_stage #(
      .COORD_WIDTH(COORD_WIDTH),
      .EDGE(lswc_pkg::edge_sel_t'(k))
    ) u_stage (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(v[k]), .in_vis(vis[k]),
      .in_x1(x1[k]), .in_y1(y1[k]), .in_x2(x2[k]), .in_y2(y2[k]),
      .edge_val(edges[k]),
      .out_valid(v[k+1]), .out_vis(vis[k+1]),
      .out_x1(x1[k+1]), .out_y1(y1[k+1]), .out_x2(x2[k+1]), .out_y2(y2[k+1])
    );
  end

  logic ok;
  always_comb begin
    ok = vis[4]
      && (x1[4] >= x_min_r) && (x1[4] <= x_max_r) && (y1[4] >= y_min_r) && (y1[4] <= y_max_r)
      && (x2[4] >= x_min_r) && (x2[4] <= x_max_r) && (y2[4] >= y_min_r) && (y2[4] <= y_max_r);
  end

  logic                          vis_r;
  logic signed [COORD_WIDTH-1:0] ox1_r, oy1_r, ox2_r, oy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v[4];
    end
    if (en) begin
      vis_r <= ok;
      ox1_r <= ok ? x1[4] : '0;
      oy1_r <= ok ? y1[4] : '0;
      ox2_r <= ok ? x2[4] : '0;
      oy2_r <= ok ? y2[4] : '0;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.visible = vis_r;
  assign out_ch.clipped_start_x = ox1_r;
  assign out_ch.clipped_start_y = oy1_r;
  assign out_ch.clipped_end_x = ox2_r;
  assign out_ch.clipped_end_y = oy2_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.clipped_start_x))
    else $error("result dropped under stall");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.visible |-> out_ch.clipped_start_x == '0 && out_ch.clipped_end_y == '0)
    else $error("rejected result carries coordinates");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("request taken while pipeline stalled");

endmodule
`default_nettype wire

// File: test/lswc_clip_checker.sv
// ----------------------------------------------------------------------------
// Line segment clipper checker
// Watches the segment, result and register write channels, clips every
// accepted segment request against its own copy of the window and compares
// each result field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module lswc_clip_checker (
  input wire clk,
  input wire rst_n,
  lswc_seg_if.sink in_ch,
  lswc_res_if.sink out_ch,
  lswc_cfg_if.sink cfg_ch,
  output int errors,
  output int pending
);

  typedef logic signed [lswc_pkg::COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
    logic   vis;
  } clip_res_t;

  clip_res_t expected_q[$];
  coord_t win_x_min, win_y_min, win_x_max, win_y_max;

  function automatic longint div_trunc(longint n, longint t, longint d);
    if (d == 0) return 0;
    return (n * t) / d;
  endfunction

  function automatic bit is_out(lswc_pkg::edge_sel_t k, longint x, longint y);
    case (k)
      lswc_pkg::EDGE_TOP:    return y > longint'(win_y_max);
      lswc_pkg::EDGE_BOTTOM: return y < longint'(win_y_min);
      lswc_pkg::EDGE_RIGHT:  return x > longint'(win_x_max);
      default:               return x < longint'(win_x_min);
    endcase
  endfunction

  function automatic clip_res_t clip_segment(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    longint x1, y1, x2, y2, e;
    bit vis, o1, o2;
    lswc_pkg::edge_sel_t k;
    clip_res_t r;
    x1 = ax; y1 = ay; x2 = bx; y2 = by;
    vis = 1;
    for (int i = 0; i < 4 && vis; i++) begin
      k = lswc_pkg::edge_sel_t'(i);
      case (k)
        lswc_pkg::EDGE_TOP:    e = win_y_max;
        lswc_pkg::EDGE_BOTTOM: e = win_y_min;
        lswc_pkg::EDGE_RIGHT:  e = win_x_max;
        default:               e = win_x_min;
      endcase
      o1 = is_out(k, x1, y1);
      o2 = is_out(k, x2, y2);
      if (o1 && o2) begin
        vis = 0;
      end else begin
        if (k == lswc_pkg::EDGE_TOP || k == lswc_pkg::EDGE_BOTTOM) begin
          if (o1) begin
            x1 = x1 + div_trunc(x2 - x1, e - y1, y2 - y1);
            y1 = e;
          end
          if (o2) begin
            x2 = x2 + div_trunc(x1 - x2, e - y2, y1 - y2);
            y2 = e;
          end
        end else begin
          if (o1) begin
            y1 = y1 + div_trunc(y2 - y1, e - x1, x2 - x1);
            x1 = e;
          end
          if (o2) begin
            y2 = y2 + div_trunc(y1 - y2, e - x2, x1 - x2);
            x2 = e;
          end
        end
      end
    end
    for (int i = 0; i < 4 && vis; i++) begin
      if (is_out(lswc_pkg::edge_sel_t'(i), x1, y1) || is_out(lswc_pkg::edge_sel_t'(i), x2, y2))
        vis = 0;
    end
    r = '0;
    if (vis) begin
      r.sx = coord_t'(x1);
      r.sy = coord_t'(y1);
      r.ex = coord_t'(x2);
      r.ey = coord_t'(y2);
      r.vis = 1'b1;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    clip_res_t want;
    if (!rst_n) begin
      win_x_min <= 0;
      win_y_min <= 0;
      win_x_max <= 32767;
      win_y_max <= 32767;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (lswc_pkg::cfg_reg_t'(cfg_ch.index))
          lswc_pkg::REG_X_MIN: win_x_min <= cfg_ch.data;
          lswc_pkg::REG_Y_MIN: win_y_min <= cfg_ch.data;
          lswc_pkg::REG_X_MAX: win_x_max <= cfg_ch.data;
          lswc_pkg::REG_Y_MAX: win_y_max <= cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_q.push_back(clip_segment(in_ch.start_x, in_ch.start_y,
                                          in_ch.end_x, in_ch.end_y));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $display("[%0t] result with no request outstanding", $time);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.clipped_start_x !== want.sx)
            report_mismatch("clipped_start_x", out_ch.clipped_start_x, want.sx);
          if (out_ch.clipped_start_y !== want.sy)
            report_mismatch("clipped_start_y", out_ch.clipped_start_y, want.sy);
          if (out_ch.clipped_end_x !== want.ex)
            report_mismatch("clipped_end_x", out_ch.clipped_end_x, want.ex);
          if (out_ch.clipped_end_y !== want.ey)
            report_mismatch("clipped_end_y", out_ch.clipped_end_y, want.ey);
          if (out_ch.visible !== want.vis)
            report_mismatch("visible", out_ch.visible, want.vis);
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: test/tb_line_segment_window_clipper.sv
// ----------------------------------------------------------------------------
// Line segment clipper testbench
// Drives directed and random segment requests through several window
// settings and flow-control phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_line_segment_window_clipper;

  localparam int DRAIN_CYCLES = 4 * (lswc_pkg::COORD_WIDTH + 4) + 20;

  typedef logic signed [lswc_pkg::COORD_WIDTH-1:0] coord_t;

  logic clk = 0;
  logic rst_n = 0;
  int errors;
  int pending;
  int in_idle_pct;
  int out_stall_pct;

  lswc_seg_if in_ch ();
  lswc_res_if out_ch ();
  lswc_cfg_if cfg_ch ();

  line_segment_window_clipper dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  lswc_clip_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .errors(errors), .pending(pending)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.start_x = '0;
    in_ch.start_y = '0;
    in_ch.end_x = '0;
    in_ch.end_y = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_stall_pct);
  end

  task automatic write_reg(lswc_pkg::cfg_reg_t idx, coord_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic set_window(int xl, int yl, int xh, int yh);
    write_reg(lswc_pkg::REG_X_MIN, coord_t'(xl));
    write_reg(lswc_pkg::REG_Y_MIN, coord_t'(yl));
    write_reg(lswc_pkg::REG_X_MAX, coord_t'(xh));
    write_reg(lswc_pkg::REG_Y_MAX, coord_t'(yh));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic send_segment(int sx, int sy, int ex, int ey);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.start_x <= coord_t'(sx);
    in_ch.start_y <= coord_t'(sy);
    in_ch.end_x <= coord_t'(ex);
    in_ch.end_y <= coord_t'(ey);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int near_edge(int e);
    int v;
    v = e + $signed($urandom_range(8)) - 4;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int any_coord();
    return $signed(16'($urandom()));
  endfunction

  task automatic random_phase(int count, int xl, int yl, int xh, int yh);
    int c[4];
    for (int n = 0; n < count; n++) begin
      for (int j = 0; j < 4; j++) begin
        case ($urandom_range(3))
          0: c[j] = any_coord();
          1: c[j] = near_edge((j % 2) ? yl : xl);
          2: c[j] = near_edge((j % 2) ? yh : xh);
          default: c[j] = (j % 2) ? $urandom_range(yh - yl) + yl
                                  : $urandom_range(xh - xl) + xl;
        endcase
      end
      send_segment(c[0], c[1], c[2], c[3]);
    end
  endtask

  initial begin
    in_idle_pct = 0;
    out_stall_pct = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, 32767, -32768, -32768);
    send_segment(100, 200, 300, 400);
    send_segment(0, 0, 32767, 32767);
    send_segment(-5, 10, -1, 20);
    send_segment(10, -5, 20, -1);
    send_segment(-100, 50, 50, -100);
    send_segment(5, 5, 5, 5);
    send_segment(-32768, 100, 32767, 100);
    send_segment(100, -32768, 100, 32767);
    drain();

    set_window(-100, -50, 100, 50);
    send_segment(-200, 0, 200, 0);
    send_segment(0, -200, 0, 200);
    send_segment(-200, -200, 200, 200);
    send_segment(-200, 60, 200, 60);
    send_segment(150, -300, 300, 150);
    send_segment(-100, -50, 100, 50);
    send_segment(-32768, 32767, 32767, -32768);
    send_segment(-101, 0, -101, 10);
    drain();

    set_window(10, 10, -10, -10);
    send_segment(0, 0, 1, 1);
    send_segment(-20, -20, 20, 20);
    drain();

    set_window(-32768, -32768, 32767, 32767);
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(-32768, 32767, 32767, -32768);
    drain();

    in_idle_pct = 0;  out_stall_pct = 0;
    set_window(-1000, -800, 1200, 900);
    random_phase(350, -1000, -800, 1200, 900);
    drain();

    in_idle_pct = 72; out_stall_pct = 0;
    set_window(-32768, -32768, 32767, 32767);
    random_phase(300, -32768, -32768, 32767, 32767);
    drain();

    in_idle_pct = 0;  out_stall_pct = 72;
    set_window(0, 0, 32767, 32767);
    random_phase(350, 0, 0, 32767, 32767);
    drain();

    in_idle_pct = 26; out_stall_pct = 26;
    set_window(-30000, 20, 5, 31000);
    random_phase(300, -30000, 20, 5, 31000);
    drain();

    in_idle_pct = 0;  out_stall_pct = 0;
    set_window(-7, -3, 9, 4);
    random_phase(200, -7, -3, 9, 4);
    drain();

    if (errors == 0) begin
      $display("** line_segment_window_clipper: PASSED **");
    end else begin
      $display("** line_segment_window_clipper: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("** line_segment_window_clipper: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
src/lswc_pkg.sv
src/lswc_if.sv
src/lswc_stage.sv
src/line_segment_window_clipper.sv
test/lswc_clip_checker.sv
test/tb_line_segment_window_clipper.sv
